>>> sv/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types, character codes and helpers of the C escape string decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

  // Most bytes one string may hold, saturated so the length fits 6 bits
  localparam int unsigned MaxBytes = 63;
  localparam int unsigned LenW     = 6;
  localparam logic [LenW-1:0] Capacity =
    (MaxBytes > 63) ? LenW'(63) : LenW'(MaxBytes);

  // Character codes
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChX         = 8'h78;
  localparam logic [7:0] ChN         = 8'h6e;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChV         = 8'h76;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChCr        = 8'h0d;
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChFormFeed  = 8'h0c;
  localparam logic [7:0] ChVtab      = 8'h0b;
  localparam logic [7:0] ChSpace     = 8'h20;

  // Decoder phase, one-hot
  typedef enum logic [6:0] {
    PhPlain = 7'b000_0001,
    PhEsc   = 7'b000_0010,
    PhOct1  = 7'b000_0100,
    PhOct2  = 7'b000_1000,
    PhHex0  = 7'b001_0000,
    PhHex1  = 7'b010_0000,
    PhHex2  = 7'b100_0000
  } phase_e;

  // One result word
  typedef struct packed {
    logic            byte_valid;
    logic [7:0]      out_byte;
    logic            end_of_string;
    logic [LenW-1:0] length;
  } result_t;

  // Up to two results produced by one character
  typedef struct packed {
    logic    has0;
    logic    has1;
    result_t res0;
    result_t res1;
  } step_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

endpackage

>>> sv/ced_decode.sv
// ----------------------------------------------------------------------------
// ced_decode
// Escape state registers and the single-pass decode of one character.
// ----------------------------------------------------------------------------
module ced_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  logic [7:0]          ch_i,
  output ced_pkg::step_t      step_o
);

  ced_pkg::phase_e            phase_q, phase_d;
  logic [7:0]                 esc_q, esc_d;
  logic [ced_pkg::LenW-1:0]   cnt_q, cnt_d, cnt1;

  logic       is_oct, is_hex;
  logic [3:0] hex_val;
  logic       pre_vld;
  logic [7:0] pre_byte;
  logic       do_plain;
  logic       main_byte_vld, main_end;
  logic [7:0] main_byte;
  ced_pkg::result_t pre_res, main_res;

  // Digit classification
  always_comb begin
    is_oct  = (ch_i >= 8'h30) && (ch_i <= 8'h37);
    is_hex  = 1'b0;
    hex_val = ch_i[3:0];
    if ((ch_i >= 8'h30) && (ch_i <= 8'h39)) begin
      is_hex = 1'b1;
    end else if (((ch_i >= 8'h61) && (ch_i <= 8'h66)) ||
                 ((ch_i >= 8'h41) && (ch_i <= 8'h46))) begin
      is_hex  = 1'b1;
      hex_val = 4'(ch_i[3:0] + 4'd9);
    end
  end

  // Phase logic: pending escape flush, then plain handling
  always_comb begin
    phase_d       = phase_q;
    esc_d         = esc_q;
    pre_vld       = 1'b0;
    pre_byte      = esc_q;
    do_plain      = 1'b0;
    main_byte_vld = 1'b0;
    main_end      = 1'b0;
    main_byte     = ch_i;

    unique case (phase_q)
      ced_pkg::PhEsc: begin
        phase_d = ced_pkg::PhPlain;
        unique case (ch_i)
          ced_pkg::ChNul: main_end = 1'b1;
          ced_pkg::ChN: begin main_byte_vld = 1'b1; main_byte = ced_pkg::ChNewline;  end
          ced_pkg::ChR: begin main_byte_vld = 1'b1; main_byte = ced_pkg::ChCr;       end
          ced_pkg::ChB: begin main_byte_vld = 1'b1; main_byte = ced_pkg::ChBackspace; end
          ced_pkg::ChT: begin main_byte_vld = 1'b1; main_byte = ced_pkg::ChTab;      end
          ced_pkg::ChF: begin main_byte_vld = 1'b1; main_byte = ced_pkg::ChFormFeed; end
          ced_pkg::ChV: begin main_byte_vld = 1'b1; main_byte = ced_pkg::ChVtab;     end
          ced_pkg::ChX: begin
            phase_d = ced_pkg::PhHex0;
            esc_d   = '0;
          end
          default: begin
            if (is_oct) begin
              esc_d   = {5'd0, ch_i[2:0]};
              phase_d = ced_pkg::PhOct1;
            end else begin
              main_byte_vld = 1'b1;
            end
          end
        endcase
      end
      ced_pkg::PhOct1: begin
        if (is_oct) begin
          esc_d   = {esc_q[4:0], ch_i[2:0]};
          phase_d = ced_pkg::PhOct2;
        end else begin
          pre_vld  = 1'b1;
          do_plain = 1'b1;
        end
      end
      ced_pkg::PhOct2: begin
        esc_d = '0;
        if (is_oct) begin
          main_byte_vld = 1'b1;
          main_byte     = {esc_q[4:0], ch_i[2:0]};
          phase_d       = ced_pkg::PhPlain;
        end else begin
          pre_vld  = 1'b1;
          do_plain = 1'b1;
        end
      end
      ced_pkg::PhHex0: begin
        if (is_hex) begin
          esc_d   = {4'd0, hex_val};
          phase_d = ced_pkg::PhHex1;
        end else begin
          pre_vld  = 1'b1;
          pre_byte = ced_pkg::ChX;
          do_plain = 1'b1;
        end
      end
      ced_pkg::PhHex1: begin
        if (is_hex) begin
          esc_d   = {esc_q[3:0], hex_val};
          phase_d = ced_pkg::PhHex2;
        end else begin
          pre_vld  = 1'b1;
          do_plain = 1'b1;
        end
      end
      ced_pkg::PhHex2: begin
        esc_d = '0;
        if (is_hex) begin
          main_byte_vld = 1'b1;
          main_byte     = {esc_q[3:0], hex_val};
          phase_d       = ced_pkg::PhPlain;
        end else begin
          pre_vld  = 1'b1;
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase

    // count after a flushed escape byte
    cnt1 = cnt_q + {{(ced_pkg::LenW-1){1'b0}}, pre_vld};

    // plain character handling
    if (do_plain) begin
      phase_d = ced_pkg::PhPlain;
      if ((ch_i == ced_pkg::ChNul) || ced_pkg::is_space(ch_i) ||
          (cnt1 >= ced_pkg::Capacity)) begin
        main_end = 1'b1;
      end else if (ch_i == ced_pkg::ChBackslash) begin
        phase_d = ced_pkg::PhEsc;
      end else begin
        main_byte_vld = 1'b1;
      end
    end

    // counter and string restart
    if (main_end) begin
      phase_d = ced_pkg::PhPlain;
      esc_d   = '0;
      cnt_d   = '0;
    end else if (main_byte_vld) begin
      cnt_d = cnt1 + 1'b1;
    end else begin
      cnt_d = cnt1;
    end
  end

  // Result words
  always_comb begin
    pre_res.byte_valid    = 1'b1;
    pre_res.out_byte      = pre_byte;
    pre_res.end_of_string = 1'b0;
    pre_res.length        = cnt1;

    main_res.byte_valid    = main_byte_vld;
    main_res.out_byte      = main_byte_vld ? main_byte : 8'd0;
    main_res.end_of_string = main_end;
    main_res.length        = main_end ? cnt1 : cnt1 + 1'b1;

    if (pre_vld) begin
      step_o.has0 = 1'b1;
      step_o.res0 = pre_res;
      step_o.has1 = main_byte_vld | main_end;
      step_o.res1 = main_res;
    end else begin
      step_o.has0 = main_byte_vld | main_end;
      step_o.res0 = main_res;
      step_o.has1 = 1'b0;
      step_o.res1 = main_res;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ced_pkg::PhPlain;
      esc_q   <= '0;
      cnt_q   <= '0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> sv/ced_out_buf.sv
// ----------------------------------------------------------------------------
// ced_out_buf
// Output register with one overflow slot for the second result of a word.
// ----------------------------------------------------------------------------
module ced_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ced_pkg::step_t    step_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ced_pkg::result_t  res_o
);

  logic             out_vld_q, hold_vld_q;
  ced_pkg::result_t out_q, hold_q;
  logic             slot_open, move_hold, load_out;

  // Output slot frees when empty or being taken
  assign slot_open = !out_vld_q || out_ready_i;
  assign free_o    = !hold_vld_q && slot_open;
  assign move_hold = hold_vld_q && slot_open;
  assign load_out  = load_i && step_i.has0;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else if (move_hold) begin
      out_vld_q  <= 1'b1;
      hold_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q  <= 1'b1;
      hold_vld_q <= step_i.has1;
    end else if (out_ready_i) begin
      out_vld_q  <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (move_hold) begin
      out_q <= hold_q;
    end else if (load_out) begin
      out_q  <= step_i.res0;
      hold_q <= step_i.res1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

>>> sv/c_escape_string_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_string_decoder
// Decodes a stream of C-escaped characters into bytes and end-of-string words.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / ch_i) takes one character per word.
// Output channel (out_valid_o / out_ready_i) delivers result words: a decoded
// byte (byte_valid_o = 1, running length) or the end word of a string
// (end_of_string_o = 1, out_byte_o = 0, final length). A NUL, unescaped
// whitespace or a character arriving once the string is full ends the string;
// the next character starts a new one.
// A character is held in the input register, then its result words in the
// result register before they show on the output.
// Throughput: one character per cycle while the output is not stalled. A
// character cutting short an open numeric escape gives two words; the second
// sits in an overflow slot; the input holds off until it reaches the output.
// Reset clears the escape state, the byte count and both output slots.
// When the receiver stalls, the result register and the input register hold
// their words and in_ready_o drops once both are occupied.
// ----------------------------------------------------------------------------
module c_escape_string_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic [7:0] out_byte_o,
  output logic       end_of_string_o,
  output logic [5:0] length_o
);

  logic             in_vld_q;
  logic [7:0]       ch_q;
  logic             free, consume, in_accept;
  ced_pkg::step_t   step;
  ced_pkg::result_t res;

  assign consume    = in_vld_q && free;
  assign in_ready_o = !in_vld_q || free;
  assign in_accept  = in_valid_i && in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (consume) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ch_q <= ch_i;
    end
  end

  // Decode
  ced_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (consume),
    .ch_i      (ch_q),
    .step_o    (step)
  );

  // Result register
  ced_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume),
    .step_i      (step),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign byte_valid_o    = res.byte_valid;
  assign out_byte_o      = res.out_byte;
  assign end_of_string_o = res.end_of_string;
  assign length_o        = res.length;

  // Checks
  a_second_word_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && step.has1 |=> out_valid_o)
    else $error("second result of a word lost");

  a_first_word_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && step.has0 |=> out_valid_o)
    else $error("result of a word not presented");

  a_end_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_string_o |-> !byte_valid_o && (out_byte_o == 8'd0))
    else $error("end word carries a byte");

  a_byte_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |->
      (length_o != 6'd0) && (length_o <= ced_pkg::Capacity) && !end_of_string_o)
    else $error("byte word length out of range");

endmodule

>>> test/escape_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_decode_checker
// Watches both channels of the escape decoder, predicts every result word
// from the accepted characters and compares the delivered words in order.
// ----------------------------------------------------------------------------
module escape_decode_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] ch_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       byte_valid_i,
  input  logic [7:0] out_byte_i,
  input  logic       end_of_string_i,
  input  logic [5:0] length_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         words_checked_o
);

  // Digit and hex letter bounds
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit7 = 8'h37;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;

  // Shadow decoder state
  ced_pkg::phase_e          dec_phase;
  logic [7:0]               esc_val;
  logic [ced_pkg::LenW-1:0] byte_cnt;

  ced_pkg::result_t expected_words[$];
  ced_pkg::result_t want;
  int               errors;
  int               checked;

  // Decoded byte word; the running length counts this byte
  task automatic push_byte(input logic [7:0] b);
    ced_pkg::result_t w;
    byte_cnt        = byte_cnt + 1'b1;
    w.byte_valid    = 1'b1;
    w.out_byte      = b;
    w.end_of_string = 1'b0;
    w.length        = byte_cnt;
    expected_words.push_back(w);
  endtask

  // End word carries the final length and starts a fresh string
  task automatic push_end();
    ced_pkg::result_t w;
    w.byte_valid    = 1'b0;
    w.out_byte      = 8'h00;
    w.end_of_string = 1'b1;
    w.length        = byte_cnt;
    expected_words.push_back(w);
    dec_phase = ced_pkg::PhPlain;
    esc_val   = 8'h00;
    byte_cnt  = '0;
  endtask

  // Character outside any escape; capacity is checked here only
  task automatic take_plain(input logic [7:0] c);
    dec_phase = ced_pkg::PhPlain;
    if (c == ced_pkg::ChNul || c == ced_pkg::ChSpace ||
        (c >= ced_pkg::ChTab && c <= ced_pkg::ChCr) ||
        byte_cnt >= ced_pkg::Capacity) begin
      push_end();
    end else if (c == ced_pkg::ChBackslash) begin
      dec_phase = ced_pkg::PhEsc;
    end else begin
      push_byte(c);
    end
  endtask

  // Advance the shadow decoder by one accepted character
  task automatic decode_char(input logic [7:0] c);
    logic       is_oct;
    logic       is_hex;
    logic [3:0] nib;
    is_oct = (c >= ChDigit0) && (c <= ChDigit7);
    is_hex = 1'b1;
    nib    = c[3:0];
    if ((c >= ChLowerA && c <= ChLowerF) || (c >= ChUpperA && c <= ChUpperF)) begin
      nib = c[3:0] + 4'd9;
    end else if (!(c >= ChDigit0 && c <= ChDigit9)) begin
      is_hex = 1'b0;
    end

    case (dec_phase)
      ced_pkg::PhEsc: begin
        dec_phase = ced_pkg::PhPlain;
        case (c)
          ced_pkg::ChNul: push_end();
          ced_pkg::ChN:   push_byte(ced_pkg::ChNewline);
          ced_pkg::ChR:   push_byte(ced_pkg::ChCr);
          ced_pkg::ChB:   push_byte(ced_pkg::ChBackspace);
          ced_pkg::ChT:   push_byte(ced_pkg::ChTab);
          ced_pkg::ChF:   push_byte(ced_pkg::ChFormFeed);
          ced_pkg::ChV:   push_byte(ced_pkg::ChVtab);
          ced_pkg::ChX: begin
            dec_phase = ced_pkg::PhHex0;
            esc_val   = 8'h00;
          end
          default: begin
            if (is_oct) begin
              esc_val   = {5'd0, c[2:0]};
              dec_phase = ced_pkg::PhOct1;
            end else begin
              push_byte(c);
            end
          end
        endcase
      end
      ced_pkg::PhOct1: begin
        if (is_oct) begin
          esc_val   = {esc_val[4:0], c[2:0]};
          dec_phase = ced_pkg::PhOct2;
        end else begin
          push_byte(esc_val);
          take_plain(c);
        end
      end
      ced_pkg::PhOct2: begin
        if (is_oct) begin
          push_byte({esc_val[4:0], c[2:0]});
          dec_phase = ced_pkg::PhPlain;
        end else begin
          push_byte(esc_val);
          take_plain(c);
        end
        esc_val = 8'h00;
      end
      ced_pkg::PhHex0: begin
        if (is_hex) begin
          esc_val   = {4'd0, nib};
          dec_phase = ced_pkg::PhHex1;
        end else begin
          push_byte(ced_pkg::ChX);
          take_plain(c);
        end
      end
      ced_pkg::PhHex1: begin
        if (is_hex) begin
          esc_val   = {esc_val[3:0], nib};
          dec_phase = ced_pkg::PhHex2;
        end else begin
          push_byte(esc_val);
          take_plain(c);
        end
      end
      ced_pkg::PhHex2: begin
        if (is_hex) begin
          push_byte({esc_val[3:0], nib});
          dec_phase = ced_pkg::PhPlain;
        end else begin
          push_byte(esc_val);
          take_plain(c);
        end
        esc_val = 8'h00;
      end
      default: take_plain(c);
    endcase
  endtask

  // Predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_phase = ced_pkg::PhPlain;
      esc_val   = 8'h00;
      byte_cnt  = '0;
      expected_words.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_char(ch_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: word with nothing expected: byte_valid=%0b out_byte=%02h",
                   $time, byte_valid_i, out_byte_i);
          $display("%0t:   eos=%0b len=%0d", $time, end_of_string_i, length_i);
          errors++;
        end else begin
          want = expected_words.pop_front();
          checked++;
          if (byte_valid_i !== want.byte_valid) begin
            $display("%0t: byte_valid expected %0b, got %0b",
                     $time, want.byte_valid, byte_valid_i);
            errors++;
          end
          if (out_byte_i !== want.out_byte) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte, out_byte_i);
            errors++;
          end
          if (end_of_string_i !== want.end_of_string) begin
            $display("%0t: end_of_string expected %0b, got %0b",
                     $time, want.end_of_string, end_of_string_i);
            errors++;
          end
          if (length_i !== want.length) begin
            $display("%0t: length expected %0d, got %0d", $time, want.length, length_i);
            errors++;
          end
        end
      end
    end
    fail_count_o    <= errors;
    pending_o       <= expected_words.size();
    words_checked_o <= checked;
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives escaped text into the C escape string decoder: a short list of
// corner cases, then random strings of escapes and plain text, with random
// gaps on input and random stalls on output. The checker scores the words.
// ----------------------------------------------------------------------------
module tb;

  localparam int IdlePct     = 29;
  localparam int ItemTarget  = 1550;
  localparam int CalmFirst   = 700;
  localparam int CalmLast    = 1000;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 8;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] ch;
  logic       out_valid;
  logic       out_ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       eos;
  logic [5:0] out_length;

  int fail_count;
  int pending;
  int words_checked;
  int chars_sent;
  int strings_sent;
  int full_strings;
  int stall_cycles;
  bit calm;

  c_escape_string_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .ch_i           (ch),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .byte_valid_o   (byte_valid),
    .out_byte_o     (out_byte),
    .end_of_string_o(eos),
    .length_o       (out_length)
  );

  escape_decode_checker decode_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .ch_i           (ch),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .byte_valid_i   (byte_valid),
    .out_byte_i     (out_byte),
    .end_of_string_i(eos),
    .length_i       (out_length),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .words_checked_o(words_checked)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Receiver stalls at random except during the calm stretch
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // Watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One character word, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] c);
    calm = (chars_sent >= CalmFirst) && (chars_sent < CalmLast);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    ch       <= c;
    do @(posedge clk_i); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  // Random string of escape sequences and plain text, then a terminator
  task automatic send_random_string();
    string      octal_set = "01234567";
    string      hex_set   = "0123456789abcdefABCDEF";
    string      letters   = "nrbtfv";
    int         n_tokens;
    int         kind;
    int         ndig;
    bit         fill;
    logic [7:0] blank;
    fill     = ($urandom_range(0, 19) == 0);
    n_tokens = fill ? $urandom_range(60, 75) : $urandom_range(0, 12);
    strings_sent++;
    if (fill) begin
      full_strings++;
    end
    for (int t = 0; t < n_tokens; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        send_char(8'($urandom_range(8'h21, 8'h7e)));
      end else if (kind < 45) begin
        send_char(8'($urandom_range(128, 255)));
      end else if (kind < 50) begin
        send_char($urandom_range(0, 1) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(14, 31)));
      end else if (kind < 62) begin
        send_char(ced_pkg::ChBackslash);
        send_char(letters[$urandom_range(0, 5)]);
      end else if (kind < 74) begin
        send_char(ced_pkg::ChBackslash);
        ndig = $urandom_range(1, 3);
        for (int d = 0; d < ndig; d++) begin
          send_char(octal_set[$urandom_range(0, 7)]);
        end
      end else if (kind < 86) begin
        send_char(ced_pkg::ChBackslash);
        send_char(ced_pkg::ChX);
        ndig = $urandom_range(0, 3);
        for (int d = 0; d < ndig; d++) begin
          send_char(hex_set[$urandom_range(0, 21)]);
        end
      end else if (kind < 96) begin
        send_char(ced_pkg::ChBackslash);
        send_char(8'($urandom_range(1, 255)));
      end else begin
        send_char(8'($urandom_range(0, 255)));
      end
    end

    // Terminator; sometimes none, so the next string runs on
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_char(ced_pkg::ChNul);
      4, 5, 6, 7: begin
        case ($urandom_range(0, 5))
          0:       blank = ced_pkg::ChSpace;
          1:       blank = ced_pkg::ChTab;
          2:       blank = ced_pkg::ChNewline;
          3:       blank = ced_pkg::ChVtab;
          4:       blank = ced_pkg::ChFormFeed;
          default: blank = ced_pkg::ChCr;
        endcase
        send_char(blank);
      end
      8: begin
        send_char(ced_pkg::ChBackslash);
        send_char(ced_pkg::ChNul);
      end
      default: ;
    endcase
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    ch           = 8'h00;
    chars_sent   = 0;
    strings_sent = 0;
    full_strings = 0;
    calm         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner cases
    send_char(ced_pkg::ChNul);   // empty string
    send_char(8'hff);            // top byte is plain text
    send_text("\\n\\v");
    send_text("\\777");          // octal wraps to 8 bits
    send_text("\\xfFf");         // three hex digits, mixed case
    send_text("\\xg");           // bare x
    send_text("\\8");            // 8 after backslash stands for itself
    send_text("\\ ");            // escaped space is kept
    send_text("\\12");
    send_char(ced_pkg::ChTab);   // closes the octal escape and ends the string
    send_char(ced_pkg::ChBackslash);
    send_char(ced_pkg::ChNul);   // NUL right after a backslash

    while (chars_sent < ItemTarget) begin
      send_random_string();
    end
    in_valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Decoded %0d characters: corner cases plus %0d random strings, %0d of them",
             chars_sent, strings_sent, full_strings);
    $display("long enough to fill the buffer; %0d result words checked.", words_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
